[src/aro_pkg.sv]
// Shared types and constants for the autoranging reciprocal ohmmeter core.
// Used by aro_csr, aro_div and autorange_reciprocal_ohmmeter_core.
package aro_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int BYTE_BITS   = 8;
   localparam int GAIN_BITS   = 34;
   localparam int OFFSET_BITS = 20;
   localparam int OHMS_BITS   = 35;
   localparam int INDEX_BITS  = 3;
   localparam int DIV_STEPS   = GAIN_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS);

   localparam logic [OHMS_BITS-1:0] NO_SIGNAL_OHMS = 35'd10000000000;

   // register indexes on the csr port
   localparam logic [INDEX_BITS-1:0] REG_LOW_GAIN    = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_LOW_OFFSET  = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_HIGH_GAIN   = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_HIGH_OFFSET = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_UP_LIMIT    = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_DOWN_LIMIT  = 3'd5;

   localparam logic [GAIN_BITS-1:0]   RST_LOW_GAIN    = 34'd43750000;
   localparam logic [OFFSET_BITS-1:0] RST_LOW_OFFSET  = 20'd1942;
   localparam logic [GAIN_BITS-1:0]   RST_HIGH_GAIN   = 34'd10040000000;
   localparam logic [OFFSET_BITS-1:0] RST_HIGH_OFFSET = 20'd93920;
   localparam logic [COUNT_BITS-1:0]  RST_UP_LIMIT    = 24'd350;
   localparam logic [COUNT_BITS-1:0]  RST_DOWN_LIMIT  = 24'd65529;

   typedef struct packed {
      logic [GAIN_BITS-1:0]   low_gain;
      logic [OFFSET_BITS-1:0] low_offset;
      logic [GAIN_BITS-1:0]   high_gain;
      logic [OFFSET_BITS-1:0] high_offset;
      logic [COUNT_BITS-1:0]  up_limit;
      logic [COUNT_BITS-1:0]  down_limit;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

[src/aro_csr.sv]
// Configuration register file: gains, offsets and range switch limits.
// Depends on aro_pkg.
module aro_csr
   import aro_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [INDEX_BITS-1:0]  csr_index,
   input  logic [GAIN_BITS-1:0]   csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LOW_GAIN:    cfg_in.low_gain    = csr_data;
            REG_LOW_OFFSET:  cfg_in.low_offset  = csr_data[OFFSET_BITS-1:0];
            REG_HIGH_GAIN:   cfg_in.high_gain   = csr_data;
            REG_HIGH_OFFSET: cfg_in.high_offset = csr_data[OFFSET_BITS-1:0];
            REG_UP_LIMIT:    cfg_in.up_limit    = csr_data[COUNT_BITS-1:0];
            REG_DOWN_LIMIT:  cfg_in.down_limit  = csr_data[COUNT_BITS-1:0];
            default:         cfg_in = cfg_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_gain    <= RST_LOW_GAIN;
         cfg_ff.low_offset  <= RST_LOW_OFFSET;
         cfg_ff.high_gain   <= RST_HIGH_GAIN;
         cfg_ff.high_offset <= RST_HIGH_OFFSET;
         cfg_ff.up_limit    <= RST_UP_LIMIT;
         cfg_ff.down_limit  <= RST_DOWN_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/aro_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on aro_pkg.
module aro_div
   import aro_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [GAIN_BITS-1:0]  dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output div_status_type        status,
   output logic [GAIN_BITS-1:0]  quotient
);

   logic [GAIN_BITS-1:0]  work_ff, work_in;
   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   rem_shift;
   logic [COUNT_BITS+1:0] diff;

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   // work register ends up holding the quotient
   assign quotient    = work_ff;

   always_comb begin
      rem_shift  = {rem_ff[COUNT_BITS-1:0], work_ff[GAIN_BITS-1]};
      diff       = {1'b0, rem_shift} - {2'b00, divisor_ff};
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (diff[COUNT_BITS+1]) begin
            rem_in  = rem_shift;
            work_in = {work_ff[GAIN_BITS-2:0], 1'b0};
         end else begin
            rem_in  = diff[COUNT_BITS:0];
            work_in = {work_ff[GAIN_BITS-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_fall_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("divider stopped without done");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff != '0 |-> rem_ff < {1'b0, divisor_ff})
      else $error("partial remainder not below divisor");

endmodule

[src/autorange_reciprocal_ohmmeter_core.sv]
// Top level of the autoranging reciprocal ohmmeter: sequencer, range state,
// result register. Depends on aro_pkg, aro_csr and aro_div.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | overflow_count, timer_high, timer_low
//   rsp_    | out       | rsp_valid/rsp_ready  | resistance_ohms, pulse_count, no_signal,
//           |           |                      | range_used, range_changed
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A request with a nonzero count starts the restoring divider on accept: the
// 34 quotient bits come one per cycle, and the finish state then loads the result.
// A zero count skips the divider and goes straight from idle to the finish state.
// req_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next request is taken while it is stalled.
// Reset is synchronous and returns the range to low and the registers to defaults.
module autorange_reciprocal_ohmmeter_core
   import aro_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [BYTE_BITS-1:0]        req_overflow_count,
   input  logic [BYTE_BITS-1:0]        req_timer_high,
   input  logic [BYTE_BITS-1:0]        req_timer_low,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OHMS_BITS-1:0] rsp_resistance_ohms,
   output logic [COUNT_BITS-1:0]       rsp_pulse_count,
   output logic                        rsp_no_signal,
   output logic                        rsp_range_used,
   output logic                        rsp_range_changed,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [INDEX_BITS-1:0]       csr_index,
   input  logic [GAIN_BITS-1:0]        csr_data
);

   cfg_type                 cfg;
   div_status_type          div_status;
   logic [GAIN_BITS-1:0]    quotient;
   logic                    div_start;
   logic [GAIN_BITS-1:0]    div_dividend;

   state_type               state_ff, state_in;
   logic                    range_ff, range_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OHMS_BITS-1:0]    rsp_ohms_ff, rsp_ohms_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff;
   logic                    rsp_no_signal_ff, rsp_no_signal_in;
   logic                    rsp_range_used_ff;
   logic                    rsp_changed_ff, rsp_changed_in;

   logic [3*BYTE_BITS-1:0]  raw_count;
   logic [COUNT_BITS-1:0]   req_count;
   logic                    req_fire;
   logic                    load;
   logic [OFFSET_BITS-1:0]  offset;

   aro_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   aro_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_in),
      .status   (div_status),
      .quotient (quotient)
   );

   assign raw_count    = {req_overflow_count, req_timer_high, req_timer_low};
   assign req_count    = raw_count[COUNT_BITS-1:0];
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign div_dividend = range_ff ? cfg.high_gain : cfg.low_gain;
   assign offset       = range_ff ? cfg.high_offset : cfg.low_offset;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resistance_ohms = rsp_ohms_ff;
   assign rsp_pulse_count     = rsp_count_ff;
   assign rsp_no_signal       = rsp_no_signal_ff;
   assign rsp_range_used      = rsp_range_used_ff;
   assign rsp_range_changed   = rsp_changed_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      div_start = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = req_count;
               if (req_count == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_no_signal_in = (count_ff == '0);
      rsp_ohms_in      = rsp_no_signal_in ? NO_SIGNAL_OHMS
                       : {1'b0, quotient} - {{(OHMS_BITS-OFFSET_BITS){1'b0}}, offset};
      rsp_changed_in   = !rsp_no_signal_in &&
                         ((!range_ff && count_ff < cfg.up_limit) ||
                          (range_ff && count_ff > cfg.down_limit));
      range_in         = (load && rsp_changed_in) ? !range_ff : range_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      if (load) begin
         rsp_ohms_ff       <= rsp_ohms_in;
         rsp_count_ff      <= count_ff;
         rsp_no_signal_ff  <= rsp_no_signal_in;
         rsp_range_used_ff <= range_ff;
         rsp_changed_ff    <= rsp_changed_in;
      end
   end

   a_no_signal_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_no_signal_ff |-> rsp_ohms_ff == NO_SIGNAL_OHMS)
      else $error("no-signal result without the no-signal value");

   a_no_signal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_no_signal_ff |-> !rsp_changed_ff)
      else $error("range changed on a zero count");

   a_range_flip: assert property (@(posedge clock) disable iff (reset)
      load && rsp_changed_in |=> range_ff != $past(range_ff))
      else $error("range change reported but range held");

   a_divide_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> div_status.busy || div_status.done)
      else $error("sequencer waits on an idle divider");

endmodule
